[src/psd_pkg.sv]
// ----------------------------------------------------------------------------
// psd_pkg: shared constants for the point-to-segment squared distance block
// Output width and saturation value, queue depth and the item kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package psd_pkg;

   localparam int COORD_BITS_DEFAULT = 24;
   localparam int OUT_W = 51;
   localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;

   // Result comes straight from an endpoint distance, or needs the divider.
   localparam logic KIND_DIRECT = 1'b0;
   localparam logic KIND_DIVIDE = 1'b1;

endpackage

`default_nettype wire

[src/point_segment_distance_sqd_top.sv]
// ----------------------------------------------------------------------------
// point_segment_distance_sqd_top: squared distance from a point to a segment
// Front pipeline classifies each query, a short queue decouples it from the
// back pipeline that squares the cross product and divides.
// ----------------------------------------------------------------------------
// The back pipeline includes a restoring divider that produces one quotient
// bit per stage.
// Throughput: one transaction per cycle when rsp_ready stays high.
// Reset clears only the valid bits, the queue pointers and count; data
// registers keep whatever they hold. No state carries from one query to the next.
// ----------------------------------------------------------------------------
`default_nettype none

module point_segment_distance_sqd_top #(
   parameter int COORD_BITS = psd_pkg::COORD_BITS_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire  [COORD_BITS-1:0]      req_point_x,
   input  wire  [COORD_BITS-1:0]      req_point_y,
   input  wire  [COORD_BITS-1:0]      req_start_x,
   input  wire  [COORD_BITS-1:0]      req_start_y,
   input  wire  [COORD_BITS-1:0]      req_end_x,
   input  wire  [COORD_BITS-1:0]      req_end_y,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic [psd_pkg::OUT_W-1:0]  rsp_dist_sqd
);

   localparam int QW = 2*COORD_BITS + 2;
   localparam int EW = 1 + 3*QW;

   logic          f_valid, q_full, q_empty, q_pop;
   logic          f_kind;
   logic [QW-1:0] f_direct, f_mag, f_len;
   logic [EW-1:0] q_wdata, q_rdata;

   psd_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .point_x       (req_point_x),
      .point_y       (req_point_y),
      .start_x       (req_start_x),
      .start_y       (req_start_y),
      .end_x         (req_end_x),
      .end_y         (req_end_y),
      .out_valid     (f_valid),
      .out_ready     (!q_full),
      .out_kind      (f_kind),
      .out_direct    (f_direct),
      .out_cross_mag (f_mag),
      .out_len       (f_len)
   );

   assign q_wdata = {f_kind, f_direct, f_mag, f_len};

   psd_fifo #(.WIDTH(EW)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid && !q_full),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   psd_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (!q_empty),
      .in_ready     (q_pop),
      .in_kind      (q_rdata[EW-1]),
      .in_direct    (q_rdata[3*QW-1:2*QW]),
      .in_cross_mag (q_rdata[2*QW-1:QW]),
      .in_len       (q_rdata[QW-1:0]),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_dist_sqd (rsp_dist_sqd)
   );

endmodule

`default_nettype wire

[src/psd_front.sv]
// ----------------------------------------------------------------------------
// psd_front: input pipeline and classification
// Forms the difference vectors, their products and sums, and decides whether
// the nearest point is an endpoint or lies inside the segment.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_front #(
   parameter int COORD_BITS = psd_pkg::COORD_BITS_DEFAULT
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       in_valid,
   output logic                      in_ready,
   input  wire  [COORD_BITS-1:0]     point_x,
   input  wire  [COORD_BITS-1:0]     point_y,
   input  wire  [COORD_BITS-1:0]     start_x,
   input  wire  [COORD_BITS-1:0]     start_y,
   input  wire  [COORD_BITS-1:0]     end_x,
   input  wire  [COORD_BITS-1:0]     end_y,
   output logic                      out_valid,
   input  wire                       out_ready,
   output logic                      out_kind,
   output logic [2*COORD_BITS+1:0]   out_direct,
   output logic [2*COORD_BITS+1:0]   out_cross_mag,
   output logic [2*COORD_BITS+1:0]   out_len
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2*COORD_BITS + 2;
   localparam int SW = 2*COORD_BITS + 3;
   localparam int QW = 2*COORD_BITS + 2;

   logic enable;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   logic signed [DW-1:0] ux_ff, uy_ff, vx_ff, vy_ff, wx_ff, wy_ff;
   logic signed [DW-1:0] ux_in, uy_in, vx_in, vy_in, wx_in, wy_in;

   logic signed [PW-1:0] uux_ff, uuy_ff, uvx_ff, uvy_ff, cxa_ff, cxb_ff;
   logic signed [PW-1:0] vvx_ff, vvy_ff, wwx_ff, wwy_ff;

   logic signed [SW-1:0] len_ff, dot_ff, cross_ff, vv_ff, ww_ff;
   logic signed [SW-1:0] len_in, dot_in, cross_in, vv_in, ww_in;
   logic signed [SW-1:0] cross_abs;

   logic                 kind_ff, kind_in;
   logic [QW-1:0]        direct_ff, direct_in;
   logic [QW-1:0]        mag_ff, len4_ff;

   // The whole front holds while the queue cannot take an entry.
   assign enable   = out_ready;
   assign in_ready = enable;

   assign ux_in = $signed({end_x[COORD_BITS-1], end_x})
                - $signed({start_x[COORD_BITS-1], start_x});
   assign uy_in = $signed({end_y[COORD_BITS-1], end_y})
                - $signed({start_y[COORD_BITS-1], start_y});
   assign vx_in = $signed({point_x[COORD_BITS-1], point_x})
                - $signed({start_x[COORD_BITS-1], start_x});
   assign vy_in = $signed({point_y[COORD_BITS-1], point_y})
                - $signed({start_y[COORD_BITS-1], start_y});
   assign wx_in = $signed({point_x[COORD_BITS-1], point_x})
                - $signed({end_x[COORD_BITS-1], end_x});
   assign wy_in = $signed({point_y[COORD_BITS-1], point_y})
                - $signed({end_y[COORD_BITS-1], end_y});

   assign len_in   = SW'(uux_ff) + SW'(uuy_ff);
   assign dot_in   = SW'(uvx_ff) + SW'(uvy_ff);
   assign cross_in = SW'(cxa_ff) - SW'(cxb_ff);
   assign vv_in    = SW'(vvx_ff) + SW'(vvy_ff);
   assign ww_in    = SW'(wwx_ff) + SW'(wwy_ff);

   assign cross_abs = cross_ff[SW-1] ? -cross_ff : cross_ff;

   always_comb begin
      priority if (dot_ff[SW-1] || dot_ff == '0) begin
         kind_in   = psd_pkg::KIND_DIRECT;
         direct_in = vv_ff[QW-1:0];
      end else if (dot_ff > len_ff) begin
         kind_in   = psd_pkg::KIND_DIRECT;
         direct_in = ww_ff[QW-1:0];
      end else begin
         kind_in   = psd_pkg::KIND_DIVIDE;
         direct_in = vv_ff[QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ux_ff <= ux_in;
         uy_ff <= uy_in;
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         wx_ff <= wx_in;
         wy_ff <= wy_in;

         uux_ff <= ux_ff * ux_ff;
         uuy_ff <= uy_ff * uy_ff;
         uvx_ff <= ux_ff * vx_ff;
         uvy_ff <= uy_ff * vy_ff;
         cxa_ff <= ux_ff * vy_ff;
         cxb_ff <= uy_ff * vx_ff;
         vvx_ff <= vx_ff * vx_ff;
         vvy_ff <= vy_ff * vy_ff;
         wwx_ff <= wx_ff * wx_ff;
         wwy_ff <= wy_ff * wy_ff;

         len_ff   <= len_in;
         dot_ff   <= dot_in;
         cross_ff <= cross_in;
         vv_ff    <= vv_in;
         ww_ff    <= ww_in;

         kind_ff   <= kind_in;
         direct_ff <= direct_in;
         mag_ff    <= cross_abs[QW-1:0];
         len4_ff   <= len_ff[QW-1:0];
      end
   end

   assign out_valid     = v4_ff;
   assign out_kind      = kind_ff;
   assign out_direct    = direct_ff;
   assign out_cross_mag = mag_ff;
   assign out_len       = len4_ff;

endmodule

`default_nettype wire

[src/psd_fifo.sv]
// ----------------------------------------------------------------------------
// psd_fifo: short queue between the front and the back
// Register-based first-in first-out buffer of classified entries.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_fifo #(
   parameter int WIDTH = 8
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire  [WIDTH-1:0] push_data,
   output logic             full,
   input  wire              pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int DEPTH = psd_pkg::FIFO_DEPTH;
   localparam int PW    = psd_pkg::FIFO_PTR_W;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]      count_ff;

   assign full     = (count_ff == (PW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("psd_fifo: push while full");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("psd_fifo: pop while empty");
   assert property (@(posedge clock) disable iff (reset)
                    (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("psd_fifo: occupancy did not grow on push");

endmodule

`default_nettype wire

[src/psd_back.sv]
// ----------------------------------------------------------------------------
// psd_back: squaring and division pipeline
// Squares the cross product in split partial products, then divides by the
// squared segment length one quotient bit per stage, and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_back #(
   parameter int COORD_BITS = psd_pkg::COORD_BITS_DEFAULT
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             in_valid,
   output logic                            in_ready,
   input  wire                             in_kind,
   input  wire  [2*COORD_BITS+1:0]         in_direct,
   input  wire  [2*COORD_BITS+1:0]         in_cross_mag,
   input  wire  [2*COORD_BITS+1:0]         in_len,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic [psd_pkg::OUT_W-1:0]       rsp_dist_sqd
);

   localparam int QW = 2*COORD_BITS + 2;
   localparam int LW = QW;
   localparam int MW = QW;
   localparam int H  = MW / 2;
   localparam int MH = MW - H;
   localparam int NW = 2*MW;
   localparam int EW = QW + psd_pkg::OUT_W;

   logic enable;

   // Popped entry.
   logic             b0_valid_ff, b0_kind_ff;
   logic [QW-1:0]    b0_direct_ff;
   logic [MW-1:0]    b0_mag_ff;
   logic [LW-1:0]    b0_len_ff;

   // Partial products of the squared cross product.
   logic             b1_valid_ff, b1_kind_ff;
   logic [QW-1:0]    b1_direct_ff;
   logic [LW-1:0]    b1_len_ff;
   logic [2*MH-1:0]  hh_ff;
   logic [MW-1:0]    hl_ff;
   logic [2*H-1:0]   ll_ff;
   logic [NW-1:0]    square;

   // Divider stages; index 0 is the loaded dividend.
   logic             dv_valid_ff  [QW+1];
   logic             dv_kind_ff   [QW+1];
   logic [QW-1:0]    dv_direct_ff [QW+1];
   logic [LW-1:0]    dv_len_ff    [QW+1];
   logic [LW-1:0]    dv_rem_ff    [QW+1];
   logic [QW-1:0]    dv_low_ff    [QW+1];
   logic [QW-1:0]    dv_quo_ff    [QW+1];

   logic             out_valid_ff;
   logic [psd_pkg::OUT_W-1:0] out_data_ff;
   logic [QW-1:0]    result;
   logic [EW-1:0]    result_ext;

   assign enable   = !out_valid_ff || rsp_ready;
   assign in_ready = enable && in_valid;

   assign square = (NW'(hh_ff) << (2*H)) + (NW'(hl_ff) << (H+1)) + NW'(ll_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff    <= 1'b0;
         b1_valid_ff    <= 1'b0;
         dv_valid_ff[0] <= 1'b0;
      end else if (enable) begin
         b0_valid_ff    <= in_valid;
         b1_valid_ff    <= b0_valid_ff;
         dv_valid_ff[0] <= b1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         b0_kind_ff   <= in_kind;
         b0_direct_ff <= in_direct;
         b0_mag_ff    <= in_cross_mag;
         b0_len_ff    <= in_len;

         b1_kind_ff   <= b0_kind_ff;
         b1_direct_ff <= b0_direct_ff;
         b1_len_ff    <= b0_len_ff;
         hh_ff <= b0_mag_ff[MW-1:H] * b0_mag_ff[MW-1:H];
         hl_ff <= MW'(b0_mag_ff[MW-1:H] * b0_mag_ff[H-1:0]);
         ll_ff <= b0_mag_ff[H-1:0] * b0_mag_ff[H-1:0];

         // The quotient never exceeds the squared distance to A, so the
         // upper half of the dividend is already below the divisor.
         dv_kind_ff[0]   <= b1_kind_ff;
         dv_direct_ff[0] <= b1_direct_ff;
         dv_len_ff[0]    <= b1_len_ff;
         dv_rem_ff[0]    <= square[NW-1:QW];
         dv_low_ff[0]    <= square[QW-1:0];
         dv_quo_ff[0]    <= '0;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [LW:0] trial;
      logic        fits;

      assign trial = {dv_rem_ff[k], dv_low_ff[k][QW-1]};
      assign fits  = (trial >= {1'b0, dv_len_ff[k]});

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k+1] <= 1'b0;
         end else if (enable) begin
            dv_valid_ff[k+1] <= dv_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            dv_kind_ff[k+1]   <= dv_kind_ff[k];
            dv_direct_ff[k+1] <= dv_direct_ff[k];
            dv_len_ff[k+1]    <= dv_len_ff[k];
            dv_low_ff[k+1]    <= dv_low_ff[k] << 1;
            dv_rem_ff[k+1]    <= fits ? LW'(trial - {1'b0, dv_len_ff[k]})
                                      : trial[LW-1:0];
            dv_quo_ff[k+1]    <= {dv_quo_ff[k][QW-2:0], fits};
         end
      end
   end

   assign result     = (dv_kind_ff[QW] == psd_pkg::KIND_DIVIDE) ? dv_quo_ff[QW]
                                                               : dv_direct_ff[QW];
   assign result_ext = EW'(result);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= dv_valid_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_data_ff <= (result_ext > EW'(psd_pkg::OUT_MAX)) ? psd_pkg::OUT_MAX
                                                             : result_ext[psd_pkg::OUT_W-1:0];
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_dist_sqd = out_data_ff;

endmodule

`default_nettype wire
